// ----- src/lzw_pkg.sv -----
// shared constants and types for the lzw strip decoder
`default_nettype none
package lzw_pkg;
    localparam int MAX_CODE_BITS = 12;
    localparam int STACK_DEPTH   = 4096;
    localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
    localparam int STACK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W          = STACK_AW + 1;
    localparam int CW_W          = 5;

    localparam logic [MAX_CODE_BITS-1:0] CLEAR_CODE = MAX_CODE_BITS'(256);
    localparam logic [MAX_CODE_BITS-1:0] END_CODE   = MAX_CODE_BITS'(257);
    localparam logic [MAX_CODE_BITS-1:0] FIRST_FREE = MAX_CODE_BITS'(258);
    localparam logic [MAX_CODE_BITS-1:0] CODE_LIMIT = MAX_CODE_BITS'(TABLE_SIZE - 1);
    localparam logic [CW_W-1:0]          MIN_BITS   = CW_W'(9);
    localparam logic [CW_W-1:0]          MAX_BITS   = CW_W'(MAX_CODE_BITS);

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_PULL    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       need_input;
        logic       strip_done;
    } t_result;
endpackage
`default_nettype wire

// ----- src/lzw_if.sv -----
// request and result channel interfaces
`default_nettype none
interface lzw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] in_byte;
    modport source (output valid, output op, output in_byte, input ready);
    modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface lzw_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       need_input;
    logic       strip_done;
    modport source (output valid, output out_byte, output byte_valid,
                    output need_input, output strip_done, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input need_input, input strip_done, output ready);
endinterface
`default_nettype wire

// ----- src/lzw_tiff_decoder_top.sv -----
// lzw strip decoder: bit buffer, code sequencer, table and stack memories
//
// channel    dir  handshake     payload
// i_req      in   valid/ready   op, in_byte
// o_rsp      out  valid/ready   out_byte, byte_valid, need_input, strip_done
// i_cfg_*    in   write enable  strip length in bytes (24 bits)
//
// push, restart and idle requests are handled in the idle state; a pull from a non-empty
// stack goes through a stack read, the result register and the output register.
// a pull that decodes goes from its request through a fetch step for each code fetched
// (clear codes included) and one more when the bit limit is passed, then for a code that
// is not a first literal through a walk step for each prefix chain step and one for the
// first byte, then through the emit step into the output register.
// reset is synchronous; no memory is cleared, so no clearing pass is needed.
// a stalled output holds one result and a second waits in the result register;
// requests are refused until the second moves into the output register.
`default_nettype none
module lzw_tiff_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lzw_req_if.sink          i_req,
    lzw_rsp_if.source        o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [23:0] i_cfg_wdata
);
    localparam int CB = lzw_pkg::MAX_CODE_BITS;
    localparam int AW = lzw_pkg::STACK_AW;
    localparam int SW = lzw_pkg::SP_W;
    localparam int WW = lzw_pkg::CW_W;

    typedef enum logic [2:0] {S_IDLE, S_POP, S_FETCH, S_WALK, S_EMIT} t_state;

    // memories
    logic [CB-1:0] prefix_mem [lzw_pkg::TABLE_SIZE];
    logic [7:0]    suffix_mem [lzw_pkg::TABLE_SIZE];
    logic [7:0]    stack_mem  [lzw_pkg::STACK_DEPTH];

    t_state           r_state, n_state;
    logic [23:0]      r_len;
    logic [SW-1:0]    r_sp, n_sp;
    logic [31:0]      r_buf, n_buf;
    logic [5:0]       r_bc, n_bc;
    logic [WW-1:0]    r_cw, n_cw;
    logic [CB-1:0]    r_nfc, n_nfc;
    logic [CB-1:0]    r_prev, n_prev;
    logic             r_prev_v, n_prev_v;
    logic [7:0]       r_fc, n_fc;
    logic [26:0]      r_cons, n_cons;
    logic             r_pend, n_pend;
    logic             r_fin, n_fin;
    logic [CB-1:0]    r_code, n_code;
    logic [CB-1:0]    r_incode, n_incode;
    lzw_pkg::t_result r_res, n_res;
    lzw_pkg::t_result r_out;
    logic             r_out_v;

    logic [CB-1:0] pre_q;
    logic [7:0]    suf_q, stk_q;
    logic          stk_we, tab_we;
    logic [AW-1:0] stk_waddr, stk_raddr;
    logic [7:0]    stk_wdata;

    logic          out_free;
    logic          accept;
    logic [27:0]   cons_lim;
    logic          over;
    logic [WW-1:0] grow_w, fw;
    logic [CB-1:0] fcode;
    logic [7:0]    walk_s;

    assign out_free    = !r_out_v || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // fetch: bit limit, early width growth, code extraction
    always_comb begin
        cons_lim = {1'b0, r_cons} + 28'(CB - 1);
        over     = cons_lim > {1'b0, r_len, 3'b000};
        if ({1'b0, r_nfc} >= (CB'(1) << r_cw) - (CB+1)'(1)) begin
            grow_w = (r_cw >= lzw_pkg::MAX_BITS) ? lzw_pkg::MAX_BITS : r_cw + WW'(1);
        end else begin
            grow_w = r_cw;
        end
        fw    = r_pend ? lzw_pkg::MIN_BITS : grow_w;
        fcode = CB'(r_buf >> (6'd32 - {1'b0, fw}));
    end

    // walk step: literal codes are their own suffix
    assign walk_s = (r_code < CB'(256)) ? r_code[7:0] : suf_q;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_buf    = r_buf;
        n_bc     = r_bc;
        n_cw     = r_cw;
        n_nfc    = r_nfc;
        n_prev   = r_prev;
        n_prev_v = r_prev_v;
        n_fc     = r_fc;
        n_cons   = r_cons;
        n_pend   = r_pend;
        n_fin    = r_fin;
        n_code   = r_code;
        n_incode = r_incode;
        n_res    = r_res;
        stk_we    = 1'b0;
        stk_waddr = r_sp[AW-1:0];
        stk_wdata = r_fc;
        stk_raddr = AW'(r_sp - SW'(1));
        tab_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (lzw_pkg::t_op'(i_req.op))
                        lzw_pkg::OP_PUSH: begin
                            if (!r_fin && r_bc <= 6'd24) begin
                                n_buf = r_buf | ({i_req.in_byte, 24'd0} >> r_bc);
                                n_bc  = r_bc + 6'd8;
                            end
                        end
                        lzw_pkg::OP_PULL: begin
                            if (r_sp != '0) begin
                                n_sp    = r_sp - SW'(1);
                                n_state = S_POP;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        lzw_pkg::OP_RESTART: begin
                            n_sp     = '0;
                            n_buf    = '0;
                            n_bc     = '0;
                            n_cw     = lzw_pkg::MIN_BITS;
                            n_nfc    = lzw_pkg::FIRST_FREE;
                            n_prev   = '0;
                            n_prev_v = 1'b0;
                            n_fc     = '0;
                            n_cons   = '0;
                            n_pend   = 1'b0;
                            n_fin    = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_res   = '{out_byte: stk_q, byte_valid: 1'b1,
                            need_input: 1'b0, strip_done: 1'b0};
                n_state = S_EMIT;
            end
            S_FETCH: begin
                if (r_fin) begin
                    n_res   = '{out_byte: 8'd0, byte_valid: 1'b0,
                                need_input: 1'b0, strip_done: 1'b1};
                    n_state = S_EMIT;
                end else if (over) begin
                    n_fin = 1'b1;
                end else if ({1'b0, r_bc} < {2'b0, fw}) begin
                    n_res   = '{out_byte: 8'd0, byte_valid: 1'b0,
                                need_input: 1'b1, strip_done: 1'b0};
                    n_state = S_EMIT;
                end else begin
                    n_cw   = fw;
                    n_pend = 1'b0;
                    n_buf  = r_buf << fw;
                    n_bc   = r_bc - {1'b0, fw};
                    n_cons = r_cons + 27'(fw);
                    if (fcode == lzw_pkg::END_CODE) begin
                        n_fin = 1'b1;
                    end else if (fcode == lzw_pkg::CLEAR_CODE) begin
                        n_pend   = 1'b1;
                        n_nfc    = lzw_pkg::FIRST_FREE;
                        n_prev_v = 1'b0;
                    end else if (!r_prev_v) begin
                        n_prev   = fcode;
                        n_prev_v = 1'b1;
                        n_fc     = fcode[7:0];
                        n_res    = '{out_byte: fcode[7:0], byte_valid: 1'b1,
                                     need_input: 1'b0, strip_done: 1'b0};
                        n_state  = S_EMIT;
                    end else begin
                        n_incode = fcode;
                        n_code   = fcode;
                        if (fcode >= r_nfc) begin
                            // code not yet in table: previous string plus its first byte
                            stk_we = 1'b1;
                            n_sp   = r_sp + SW'(1);
                            n_code = r_prev;
                        end
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_code >= CB'(256) && r_sp < SW'(lzw_pkg::STACK_DEPTH - 1)) begin
                    stk_we    = 1'b1;
                    stk_wdata = walk_s;
                    n_sp      = r_sp + SW'(1);
                    n_code    = pre_q;
                end else begin
                    // first byte is pushed and popped at once: emit it directly
                    n_fc = walk_s;
                    if (r_nfc < lzw_pkg::CODE_LIMIT) begin
                        tab_we = 1'b1;
                        n_nfc  = r_nfc + CB'(1);
                    end
                    n_prev  = r_incode;
                    n_res   = '{out_byte: walk_s, byte_valid: 1'b1,
                                need_input: 1'b0, strip_done: 1'b0};
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= 24'hFFFFFF;
            r_sp     <= '0;
            r_buf    <= '0;
            r_bc     <= '0;
            r_cw     <= lzw_pkg::MIN_BITS;
            r_nfc    <= lzw_pkg::FIRST_FREE;
            r_prev   <= '0;
            r_prev_v <= 1'b0;
            r_fc     <= '0;
            r_cons   <= '0;
            r_pend   <= 1'b0;
            r_fin    <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            r_sp     <= n_sp;
            r_buf    <= n_buf;
            r_bc     <= n_bc;
            r_cw     <= n_cw;
            r_nfc    <= n_nfc;
            r_prev   <= n_prev;
            r_prev_v <= n_prev_v;
            r_fc     <= n_fc;
            r_cons   <= n_cons;
            r_pend   <= n_pend;
            r_fin    <= n_fin;
            if (r_state == S_EMIT && out_free) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_incode <= n_incode;
        r_res    <= n_res;
        if (r_state == S_EMIT && out_free) begin
            r_out <= r_res;
        end
    end

    // table memories, read at the next walk code
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            prefix_mem[r_nfc] <= r_prev;
            suffix_mem[r_nfc] <= walk_s;
        end
        pre_q <= prefix_mem[n_code];
        suf_q <= suffix_mem[n_code];
    end

    // reversal stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stk_q <= stack_mem[stk_raddr];
    end

    assign o_rsp.valid      = r_out_v;
    assign o_rsp.out_byte   = r_out.out_byte;
    assign o_rsp.byte_valid = r_out.byte_valid;
    assign o_rsp.need_input = r_out.need_input;
    assign o_rsp.strip_done = r_out.strip_done;

    // stack pointer stays below the stack depth
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp < SW'(lzw_pkg::STACK_DEPTH))
        else $error("stack pointer out of range");

    // code width stays within its bounds
    a_cw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cw >= lzw_pkg::MIN_BITS && r_cw <= lzw_pkg::MAX_BITS)
        else $error("code width out of range");

    // free entry never drops below the first free code
    a_nfc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfc >= lzw_pkg::FIRST_FREE)
        else $error("next free code below first free");

    // every result carries exactly one kind of answer
    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> $onehot({r_out.byte_valid, r_out.need_input, r_out.strip_done}))
        else $error("result kind not unique");

    // a popped byte goes from the pop state to the emit state
    a_pop_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |=> r_state == S_EMIT)
        else $error("pop did not reach emit");
endmodule
`default_nettype wire
